/* rtl/core/sgtr_pkg.sv */
package sgtr_pkg;

  localparam int GLYPH_COUNT  = 94;
  localparam int GLYPH_ROWS   = 5;
  localparam int GLYPH_COLS   = 5;
  localparam int MAX_SCALE    = 8;
  localparam int FIRST_CODE   = 33;
  localparam int CELL_PITCH   = 6;
  localparam int CODE_NEWLINE = 10;
  localparam int CODE_SPACE   = 32;
  localparam int STORE_DEPTH  = 512;
  localparam int STORE_AW     = $clog2(STORE_DEPTH);
  localparam int MASK_W       = GLYPH_COLS * MAX_SCALE;
  localparam int QUEUE_DEPTH  = 4;
  localparam int IN_W         = 56;
  localparam int OUT_W        = 104;

  localparam logic [1:0] CMD_ORIGIN = 2'd0;
  localparam logic [1:0] CMD_DRAW   = 2'd1;
  localparam logic [1:0] CMD_LOAD   = 2'd2;

  localparam logic [1:0] REG_SCALE_H = 2'd0;
  localparam logic [1:0] REG_SCALE_V = 2'd1;
  localparam logic [1:0] REG_COLOR   = 2'd2;

  typedef enum logic [2:0] {
    K_ORIGIN,
    K_LOAD,
    K_NEWLINE,
    K_SPACE,
    K_DRAW
  } kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    kind_t                kind;
    logic [15:0]          x;
    logic [15:0]          y;
    logic [STORE_AW-1:0]  addr;
    logic [4:0]           bits;
  } q_entry_t;

  // Each set glyph column becomes a run of sx set bits.
  function automatic logic [MASK_W-1:0] widen_row(input logic [4:0] bits,
                                                  input logic [3:0] sx);
    logic [MASK_W-1:0] mask;
    logic [MASK_W-1:0] run;
    logic [5:0]        sh;
    mask = '0;
    run  = (MASK_W'(1) << sx) - MASK_W'(1);
    for (int c = 0; c < GLYPH_COLS; c++) begin
      sh = 6'(c) * {2'b00, sx};
      if (bits[c]) begin
        mask = mask | (run << sh);
      end
    end
    return mask;
  endfunction

endpackage

/* rtl/core/scaled_glyph_text_renderer.sv */
// A drawn character's first row write passes through the queue, the registered glyph store
// read and the output register after its request is accepted.
// The row generator writes the 5 * scale_vertical rows of a drawn character, one row write
// per cycle while out_tready does not stall it; every other request is taken in its idle
// state; a four-entry queue lets requests be accepted while rows are being written.
// Reset (synchronous, active low) clears the cursor and the queue, sets both scales to one
// and the color to all ones; the glyph store is not cleared and must be loaded before use.
module scaled_glyph_text_renderer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [1:0]                  cfg_index,
  input  logic [31:0]                 cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // command
  input  logic [1:0]                  in_tuser,
  // char_code, origin_x, origin_y, glyph_row_index, glyph_row_bits
  input  logic [sgtr_pkg::IN_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // row_x, row_y, row_mask, color
  output logic [sgtr_pkg::OUT_W-1:0]  out_tdata,
  output logic                        out_tlast
);

  logic [3:0]  scale_h_r;
  logic [3:0]  scale_v_r;
  logic [31:0] color_r;
  logic [3:0]  sx;
  logic [3:0]  sy;

  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  sgtr_pkg::q_entry_t q_in;
  sgtr_pkg::q_entry_t q_head;

  logic [15:0]                 row_x;
  logic [15:0]                 row_y;
  logic [sgtr_pkg::MASK_W-1:0] row_mask;
  logic [31:0]                 row_color;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_h_r <= 4'd1;
      scale_v_r <= 4'd1;
      color_r   <= 32'hFFFF_FFFF;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sgtr_pkg::REG_SCALE_H: scale_h_r <= cfg_wdata[3:0];
        sgtr_pkg::REG_SCALE_V: scale_v_r <= cfg_wdata[3:0];
        sgtr_pkg::REG_COLOR:   color_r   <= cfg_wdata;
        default: begin
          color_r <= color_r;
        end
      endcase
    end
  end

  // A scale of zero acts as one and values past the maximum saturate.
  always_comb begin
    sx = scale_h_r;
    sy = scale_v_r;
    if (scale_h_r == 4'd0) begin
      sx = 4'd1;
    end else if (scale_h_r > 4'(sgtr_pkg::MAX_SCALE)) begin
      sx = 4'(sgtr_pkg::MAX_SCALE);
    end
    if (scale_v_r == 4'd0) begin
      sy = 4'd1;
    end else if (scale_v_r > 4'(sgtr_pkg::MAX_SCALE)) begin
      sy = 4'(sgtr_pkg::MAX_SCALE);
    end
  end

  sgtr_front u_front (
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tuser (in_tuser),
    .in_tdata (in_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  sgtr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  sgtr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .sx        (sx),
    .sy        (sy),
    .color     (color_r),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_x     (row_x),
    .out_y     (row_y),
    .out_mask  (row_mask),
    .out_color (row_color),
    .out_last  (out_tlast)
  );

  assign out_tdata = {row_color, row_mask, row_y, row_x};

endmodule

/* rtl/core/sgtr_ram.sv */
module sgtr_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/sgtr_front.sv */
module sgtr_front (
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [1:0]                  in_tuser,
  input  logic [sgtr_pkg::IN_W-1:0]   in_tdata,
  input  logic                        q_full,
  output logic                        q_push,
  output sgtr_pkg::q_entry_t          q_entry
);

  logic [1:0]  command;
  logic [7:0]  char_code;
  logic [6:0]  glyph_num;
  logic        keep;

  assign command   = in_tuser;
  assign char_code = in_tdata[7:0];
  assign glyph_num = 7'(char_code - 8'(sgtr_pkg::FIRST_CODE));

  always_comb begin
    keep          = 1'b0;
    q_entry.kind  = sgtr_pkg::K_ORIGIN;
    q_entry.x     = in_tdata[23:8];
    q_entry.y     = in_tdata[39:24];
    q_entry.addr  = in_tdata[48:40];
    q_entry.bits  = in_tdata[53:49];
    case (command)
      sgtr_pkg::CMD_ORIGIN: begin
        keep = 1'b1;
      end
      sgtr_pkg::CMD_LOAD: begin
        keep         = 1'b1;
        q_entry.kind = sgtr_pkg::K_LOAD;
      end
      sgtr_pkg::CMD_DRAW: begin
        q_entry.addr = sgtr_pkg::STORE_AW'(glyph_num) *
                       sgtr_pkg::STORE_AW'(sgtr_pkg::GLYPH_ROWS);
        if (char_code == 8'(sgtr_pkg::CODE_NEWLINE)) begin
          keep         = 1'b1;
          q_entry.kind = sgtr_pkg::K_NEWLINE;
        end else if (char_code == 8'(sgtr_pkg::CODE_SPACE)) begin
          keep         = 1'b1;
          q_entry.kind = sgtr_pkg::K_SPACE;
        end else if ({1'b0, char_code} >= 9'(sgtr_pkg::FIRST_CODE) &&
                     {1'b0, char_code} <
                     9'(sgtr_pkg::FIRST_CODE + sgtr_pkg::GLYPH_COUNT)) begin
          keep         = 1'b1;
          q_entry.kind = sgtr_pkg::K_DRAW;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full && keep;

endmodule

/* rtl/core/sgtr_queue.sv */
module sgtr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sgtr_pkg::q_entry_t push_entry,
  input  logic               pop,
  output sgtr_pkg::q_entry_t head,
  output logic               full,
  output logic               empty
);

  localparam int PW = $clog2(sgtr_pkg::QUEUE_DEPTH);

  sgtr_pkg::q_entry_t entries_r [sgtr_pkg::QUEUE_DEPTH];
  logic [PW-1:0]      wr_ptr_r;
  logic [PW-1:0]      rd_ptr_r;
  logic [PW:0]        count_r;
  logic               do_push;
  logic               do_pop;

  assign full    = (count_r == (PW+1)'(sgtr_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (PW+1)'(1);
      end
    end
  end

endmodule

/* rtl/core/sgtr_back.sv */
module sgtr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [3:0]                    sx,
  input  logic [3:0]                    sy,
  input  logic [31:0]                   color,
  input  sgtr_pkg::q_entry_t            q_head,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_x,
  output logic [15:0]                   out_y,
  output logic [sgtr_pkg::MASK_W-1:0]   out_mask,
  output logic [31:0]                   out_color,
  output logic                          out_last
);

  sgtr_pkg::bk_state_t state_r, state_nxt;

  logic [15:0] cursor_x_r, cursor_x_nxt;
  logic [15:0] cursor_y_r, cursor_y_nxt;
  logic [15:0] line_x_r, line_x_nxt;
  logic [sgtr_pkg::STORE_AW-1:0] base_r, base_nxt;
  logic [2:0]  grp_r, grp_nxt;
  logic [2:0]  sub_r, sub_nxt;
  logic [15:0] row_y_r, row_y_nxt;

  logic        out_valid_r;
  logic [15:0] out_x_r;
  logic [15:0] out_y_r;
  logic [sgtr_pkg::MASK_W-1:0] out_mask_r;
  logic [31:0] out_color_r;
  logic        out_last_r;

  logic        out_free;
  logic        out_load;
  logic        last_sub;
  logic        last_grp;
  logic        ram_we;
  logic        ram_re;
  logic [sgtr_pkg::STORE_AW-1:0] ram_raddr;
  logic [4:0]  ram_rdata;
  logic [15:0] step_x;
  logic [15:0] step_y;

  sgtr_ram #(
    .WIDTH(5),
    .DEPTH(sgtr_pkg::STORE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(q_head.addr),
    .wr_data(q_head.bits),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  assign out_free = !out_valid_r || out_tready;
  assign last_sub = ({1'b0, sub_r} == sy - 4'd1);
  assign last_grp = (grp_r == 3'(sgtr_pkg::GLYPH_ROWS - 1));
  assign step_x   = 16'(sx) * 16'(sgtr_pkg::CELL_PITCH);
  assign step_y   = 16'(sy) * 16'(sgtr_pkg::CELL_PITCH);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sgtr_pkg::BK_IDLE: begin
        if (!q_empty && q_head.kind == sgtr_pkg::K_DRAW) begin
          state_nxt = sgtr_pkg::BK_EMIT;
        end
      end
      sgtr_pkg::BK_EMIT: begin
        if (out_free && last_sub && last_grp) begin
          state_nxt = sgtr_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = sgtr_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = q_head.addr;
    out_load     = 1'b0;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    line_x_nxt   = line_x_r;
    base_nxt     = base_r;
    grp_nxt      = grp_r;
    sub_nxt      = sub_r;
    row_y_nxt    = row_y_r;
    case (state_r)
      sgtr_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_head.kind)
            sgtr_pkg::K_ORIGIN: begin
              cursor_x_nxt = q_head.x;
              line_x_nxt   = q_head.x;
              cursor_y_nxt = q_head.y;
            end
            sgtr_pkg::K_LOAD: begin
              ram_we = 1'b1;
            end
            sgtr_pkg::K_NEWLINE: begin
              cursor_y_nxt = cursor_y_r + step_y;
              cursor_x_nxt = line_x_r;
            end
            sgtr_pkg::K_SPACE: begin
              cursor_x_nxt = cursor_x_r + step_x;
            end
            sgtr_pkg::K_DRAW: begin
              ram_re    = 1'b1;
              base_nxt  = q_head.addr;
              grp_nxt   = '0;
              sub_nxt   = '0;
              row_y_nxt = cursor_y_r;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      sgtr_pkg::BK_EMIT: begin
        ram_raddr = base_r + sgtr_pkg::STORE_AW'(grp_r) + sgtr_pkg::STORE_AW'(1);
        if (out_free) begin
          out_load  = 1'b1;
          row_y_nxt = row_y_r + 16'd1;
          if (last_sub) begin
            sub_nxt = '0;
            grp_nxt = grp_r + 3'd1;
            ram_re  = !last_grp;
            if (last_grp) begin
              cursor_x_nxt = cursor_x_r + step_x;
            end
          end else begin
            sub_nxt = sub_r + 3'd1;
          end
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    base_r  <= base_nxt;
    grp_r   <= grp_nxt;
    sub_r   <= sub_nxt;
    row_y_r <= row_y_nxt;
    if (out_load) begin
      out_x_r     <= cursor_x_r;
      out_y_r     <= row_y_r;
      out_mask_r  <= sgtr_pkg::widen_row(ram_rdata, sx);
      out_color_r <= color;
      out_last_r  <= last_sub && last_grp;
    end
    if (!rst_n) begin
      state_r     <= sgtr_pkg::BK_IDLE;
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      line_x_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      line_x_r   <= line_x_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_mask   = out_mask_r;
  assign out_color  = out_color_r;
  assign out_last   = out_last_r;

endmodule

/* test/scaled_glyph_text_renderer_test.sv */
`timescale 1ns / 100ps

module scaled_glyph_text_renderer_test;
  import sgtr_pkg::*;

  localparam int REQ_W = IN_W + 2;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [7:0] CODE_NUL = 8'd0;
  localparam logic [7:0] CODE_TAB = 8'd9;
  localparam logic [7:0] CODE_LAST_CONTROL = 8'd31;
  localparam logic [7:0] CODE_PAST_TABLE = 8'(FIRST_CODE + GLYPH_COUNT);
  localparam logic [7:0] CODE_TOP = 8'd255;
  localparam logic [7:0] CODE_FIRST_GLYPH = 8'(FIRST_CODE);
  localparam logic [7:0] CODE_LAST_GLYPH = 8'(FIRST_CODE + GLYPH_COUNT - 1);

  typedef struct packed {
    logic [15:0]       x;
    logic [15:0]       y;
    logic [MASK_W-1:0] mask;
    logic [31:0]       color;
    logic              last;
  } row_write_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [1:0]        cfg_index = REG_SCALE_H;
  logic [31:0]       cfg_wdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [1:0]        in_tuser = '0;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tlast;

  logic [3:0]        scale_h_reg = 4'd1;
  logic [3:0]        scale_v_reg = 4'd1;
  logic [31:0]       color_reg = 32'hFFFF_FFFF;
  logic [15:0]       cursor_x = '0;
  logic [15:0]       cursor_y = '0;
  logic [15:0]       line_start_x = '0;
  logic [4:0]        glyph_rows [STORE_DEPTH];
  logic              row_loaded [STORE_DEPTH];
  row_write_t        pending_rows [$];

  int                error_count = 0;
  int                stimulus_count = 0;
  int                hold_cycles_left = 0;
  logic              steady_flow = 1'b0;

  scaled_glyph_text_renderer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int effective_scale(input logic [3:0] s);
    if (s == 4'd0) return 1;
    if (s > 4'(MAX_SCALE)) return MAX_SCALE;
    return int'(s);
  endfunction

  function automatic logic [REQ_W-1:0] pack_request(input logic [1:0] cmd,
                                                    input logic [7:0] code,
                                                    input logic [15:0] ox,
                                                    input logic [15:0] oy,
                                                    input logic [8:0] idx,
                                                    input logic [4:0] bits);
    return {2'b00, bits, idx, oy, ox, code, cmd};
  endfunction

  function automatic logic glyph_ready(input int g);
    for (int k = 0; k < GLYPH_ROWS; k++) begin
      if (!row_loaded[g * GLYPH_ROWS + k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic render_request(input logic [REQ_W-1:0] data);
    logic [1:0]  cmd;
    logic [7:0]  code;
    logic [4:0]  bits;
    int          sx;
    int          sy;
    int          base;
    int          rows;
    row_write_t  w;
    cmd  = data[1:0];
    code = data[9:2];
    sx   = effective_scale(scale_h_reg);
    sy   = effective_scale(scale_v_reg);
    case (cmd)
      CMD_ORIGIN: begin
        cursor_x     = data[25:10];
        line_start_x = data[25:10];
        cursor_y     = data[41:26];
      end
      CMD_LOAD: begin
        glyph_rows[data[50:42]] = data[55:51];
      end
      CMD_DRAW: begin
        if (code == 8'(CODE_NEWLINE)) begin
          cursor_y = cursor_y + 16'(CELL_PITCH * sy);
          cursor_x = line_start_x;
        end else if (code == 8'(CODE_SPACE)) begin
          cursor_x = cursor_x + 16'(CELL_PITCH * sx);
        end else if (code >= CODE_FIRST_GLYPH && code <= CODE_LAST_GLYPH) begin
          base = (int'(code) - FIRST_CODE) * GLYPH_ROWS;
          rows = GLYPH_ROWS * sy;
          for (int r = 0; r < rows; r++) begin
            bits    = glyph_rows[base + r / sy];
            w.x     = cursor_x;
            w.y     = cursor_y + 16'(r);
            w.mask  = '0;
            for (int i = 0; i < GLYPH_COLS * sx; i++) begin
              if (bits[i / sx]) w.mask[i] = 1'b1;
            end
            w.color = color_reg;
            w.last  = (r == rows - 1);
            pending_rows.push_back(w);
          end
          cursor_x = cursor_x + 16'(CELL_PITCH * sx);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : row_checker
    row_write_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) render_request({in_tdata, in_tuser});
      if (out_tvalid && out_tready) begin
        if (pending_rows.size() == 0) begin
          $display("%0t: row write expected none, actual %h last %b", $time,
                   out_tdata, out_tlast);
          error_count++;
        end else begin
          want = pending_rows.pop_front();
          compare_field("row_x", 64'(want.x), 64'(out_tdata[15:0]));
          compare_field("row_y", 64'(want.y), 64'(out_tdata[31:16]));
          compare_field("row_mask", 64'(want.mask), 64'(out_tdata[71:32]));
          compare_field("color", 64'(want.color), 64'(out_tdata[103:72]));
          compare_field("last_row", 64'(want.last), 64'(out_tlast));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles_left != 0) begin
      out_tready <= 1'b0;
      hold_cycles_left--;
    end else begin
      out_tready <= steady_flow || ($urandom_range(0, 99) >= 24);
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] data);
    if (!steady_flow) begin
      while ($urandom_range(0, 99) < 24) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= data[1:0];
    in_tdata  <= data[REQ_W-1:2];
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_draw(input logic [7:0] code);
    send_request(pack_request(CMD_DRAW, code, 16'($urandom), 16'($urandom),
                              9'($urandom), 5'($urandom)));
  endtask

  task automatic send_origin(input logic [15:0] ox, input logic [15:0] oy);
    send_request(pack_request(CMD_ORIGIN, 8'($urandom), ox, oy, 9'($urandom),
                              5'($urandom)));
  endtask

  task automatic send_load(input logic [8:0] idx, input logic [4:0] bits);
    send_request(pack_request(CMD_LOAD, 8'($urandom), 16'($urandom), 16'($urandom),
                              idx, bits));
    row_loaded[idx] = 1'b1;
  endtask

  task automatic wait_rows_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_SCALE_H: scale_h_reg = value[3:0];
      REG_SCALE_V: scale_v_reg = value[3:0];
      default:     color_reg = value;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_settings(input logic [3:0] sh, input logic [3:0] sv,
                                input logic [31:0] color);
    wait_rows_drained();
    repeat (16) @(posedge clk);
    write_register(REG_SCALE_H, {28'($urandom), sh});
    write_register(REG_SCALE_V, {28'($urandom), sv});
    write_register(REG_COLOR, color);
  endtask

  task automatic test_glyph_loading();
    logic [4:0] first_rows [GLYPH_ROWS];
    logic [4:0] last_rows [GLYPH_ROWS];
    first_rows = '{5'h1F, 5'h00, 5'h15, 5'h0A, 5'h11};
    last_rows  = '{5'h01, 5'h02, 5'h04, 5'h08, 5'h10};
    for (int k = 0; k < GLYPH_ROWS; k++) begin
      send_load(9'(k), first_rows[k]);
    end
    for (int k = 0; k < GLYPH_ROWS; k++) begin
      send_load(9'((GLYPH_COUNT - 1) * GLYPH_ROWS + k), last_rows[k]);
    end
    send_load(9'(GLYPH_COUNT * GLYPH_ROWS), 5'h1F);
    send_load(9'(STORE_DEPTH - 1), 5'h0E);
    send_draw(CODE_FIRST_GLYPH);
    send_draw(CODE_LAST_GLYPH);
  endtask

  task automatic test_cursor_codes();
    send_origin(16'hFFFF, 16'hFFFF);
    send_draw(CODE_FIRST_GLYPH);
    send_draw(8'(CODE_SPACE));
    send_draw(CODE_LAST_GLYPH);
    send_draw(8'(CODE_NEWLINE));
    send_draw(CODE_FIRST_GLYPH);
    send_draw(CODE_NUL);
    send_draw(CODE_TAB);
    send_draw(CODE_LAST_CONTROL);
    send_draw(CODE_PAST_TABLE);
    send_draw(CODE_TOP);
    send_request({REQ_W{1'b1}} & pack_request(CMD_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF,
                                              9'h1FF, 5'h1F));
    send_origin(16'h0000, 16'h0000);
    send_draw(CODE_FIRST_GLYPH);
  endtask

  task automatic test_scale_extremes();
    apply_settings(4'd8, 4'd8, 32'h0000_0000);
    send_draw(CODE_FIRST_GLYPH);
    send_draw(8'(CODE_SPACE));
    send_draw(8'(CODE_NEWLINE));
    send_draw(CODE_LAST_GLYPH);
    apply_settings(4'd0, 4'd15, 32'hA5A5_5A5A);
    send_draw(CODE_FIRST_GLYPH);
    send_draw(8'(CODE_NEWLINE));
    apply_settings(4'd15, 4'd0, 32'hFFFF_FFFF);
    send_draw(CODE_LAST_GLYPH);
    send_draw(8'(CODE_SPACE));
  endtask

  task automatic test_output_backpressure();
    apply_settings(4'd8, 4'd8, $urandom);
    hold_cycles_left = 300;
    for (int n = 0; n < 10; n++) begin
      send_draw(n[0] ? CODE_LAST_GLYPH : CODE_FIRST_GLYPH);
    end
  endtask

  task automatic test_sender_pause();
    apply_settings(4'd2, 4'd1, $urandom);
    for (int n = 0; n < 4; n++) send_draw(CODE_FIRST_GLYPH);
    wait_rows_drained();
    for (int n = 0; n < 4; n++) send_draw(CODE_LAST_GLYPH);
  endtask

  task automatic send_random_item();
    int         pick;
    int         g;
    logic [7:0] code;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      g = $urandom_range(0, GLYPH_COUNT - 1);
      if (!glyph_ready(g) || $urandom_range(0, 9) == 0) begin
        for (int k = 0; k < GLYPH_ROWS; k++) begin
          send_load(9'(g * GLYPH_ROWS + k), 5'($urandom));
          stimulus_count++;
        end
      end
      send_draw(8'(FIRST_CODE + g));
      stimulus_count++;
    end else if (pick < 70) begin
      send_origin(16'($urandom), 16'($urandom));
      stimulus_count++;
    end else if (pick < 78) begin
      send_load(9'($urandom), 5'($urandom));
      stimulus_count++;
    end else if (pick < 90) begin
      send_draw(pick[0] ? 8'(CODE_NEWLINE) : 8'(CODE_SPACE));
      stimulus_count++;
    end else if (pick < 97) begin
      code = pick[0] ? 8'($urandom_range(0, 31)) : 8'($urandom_range(127, 255));
      send_draw(code);
    end else begin
      send_request(pack_request(CMD_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom),
                                9'($urandom), 5'($urandom)));
    end
  endtask

  task automatic test_random_traffic();
    logic [3:0] sh;
    logic [3:0] sv;
    int         target;
    for (int phase = 0; phase < 7; phase++) begin
      sh = 4'($urandom_range(0, 15));
      sv = 4'($urandom_range(0, 3));
      if (phase == 0) begin
        sh = 4'd1;
        sv = 4'd1;
      end else if (phase == 5) begin
        sh = 4'd8;
        sv = 4'd8;
      end
      apply_settings(sh, sv, $urandom);
      steady_flow = (phase == 3);
      target = stimulus_count + 50;
      while (stimulus_count < target) send_random_item();
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      glyph_rows[i] = '0;
      row_loaded[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_glyph_loading();
    test_cursor_codes();
    test_scale_extremes();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic();
    wait_rows_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_rows.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
